// ===== hdl/nmea_ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// nmea_ssp_pkg
// Types, codes and character constants of the nmea satellite status parser.
// ----------------------------------------------------------------------------
package nmea_ssp_pkg;

   localparam int CONSTELLATIONS = 4;
   localparam logic [3:0] CONST_LIMIT = 4'(CONSTELLATIONS);

   localparam logic [2:0] TALKER_GP   = 3'd0;
   localparam logic [2:0] TALKER_GL   = 3'd1;
   localparam logic [2:0] TALKER_GA   = 3'd2;
   localparam logic [2:0] TALKER_BD   = 3'd3;
   localparam logic [2:0] TALKER_NONE = 3'd4;

   localparam logic [1:0] KIND_GSV  = 2'd0;
   localparam logic [1:0] KIND_GSA  = 2'd1;
   localparam logic [1:0] KIND_GGA  = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_B      = 8'h42;
   localparam logic [7:0] CHAR_D      = 8'h44;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_L      = 8'h4C;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_S      = 8'h53;
   localparam logic [7:0] CHAR_V      = 8'h56;

   localparam logic [4:0] FIELD_ADDRESS  = 5'd0;
   localparam logic [4:0] FIELD_MODE     = 5'd2;
   localparam logic [4:0] FIELD_VISIBLE  = 5'd3;
   localparam logic [4:0] FIELD_SV_FIRST = 5'd3;
   localparam logic [4:0] FIELD_QUALITY  = 5'd6;
   localparam logic [4:0] FIELD_SV_LAST  = 5'd14;
   localparam logic [4:0] FIELD_PDOP     = 5'd15;
   localparam logic [4:0] FIELD_LAST     = 5'd31;
   localparam logic [2:0] CHAR_LAST      = 3'd7;
   localparam logic [2:0] ADDRESS_LEN    = 3'd5;

   localparam logic [3:0]  USED_MAX   = 4'd12;
   localparam logic [16:0] COUNT_MAX  = 17'd255;
   localparam logic [16:0] PDOP_MAX   = 17'd9999;
   localparam logic [13:0] PDOP_RESET = 14'd9990;

   localparam logic [1:0] FRAC_INT  = 2'd0;
   localparam logic [1:0] FRAC_DOT  = 2'd1;
   localparam logic [1:0] FRAC_ONE  = 2'd2;
   localparam logic [1:0] FRAC_DONE = 2'd3;

   typedef struct packed {
      logic [1:0]  sentence_kind;
      logic [2:0]  constellation;
      logic [7:0]  visible_count;
      logic [3:0]  used_count;
      logic [7:0]  fix_mode;
      logic [13:0] pdop_hundredths;
      logic [7:0]  fix_quality;
   } rsp_type;

endpackage

// ===== hdl/nmea_satellite_status_parser_unit.sv =====
// ----------------------------------------------------------------------------
// nmea_satellite_status_parser_unit
// Parses an nmea character stream and reports satellite status per sentence.
//
//   channel  ports              direction  beat
//   req      valid/stall/data   in         one received character
//   rsp      valid/stall/data   out        status after a gsv, gsa or gga line
//
// One character is taken every cycle while req_stall is low; its state update
// is one pass of logic. A result is registered when its line feed is taken; a
// second waits in a skid register, and req_stall is high only while it is there.
// Synchronous reset clears tables and state but sets fix mode 1 and pdop 9990.
// ----------------------------------------------------------------------------
module nmea_satellite_status_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_sentence_kind,
   output logic [2:0]  rsp_constellation,
   output logic [7:0]  rsp_visible_count,
   output logic [3:0]  rsp_used_count,
   output logic [7:0]  rsp_fix_mode,
   output logic [13:0] rsp_pdop_hundredths,
   output logic [7:0]  rsp_fix_quality
);
   import nmea_ssp_pkg::*;

   logic        in_sentence_ff, in_sentence_in;
   logic [4:0]  field_number_ff, field_number_in;
   logic [2:0]  char_in_field_ff, char_in_field_in;
   logic [2:0]  talker_code_ff, talker_code_in;
   logic [1:0]  type_code_ff, type_code_in;
   logic        field_nonempty_ff, field_nonempty_in;
   logic        digits_active_ff, digits_active_in;
   logic [1:0]  frac_digits_ff, frac_digits_in;
   logic [13:0] accumulator_ff, accumulator_in;
   logic [3:0]  used_tally_ff, used_tally_in;
   logic [7:0]  visible_table_ff [CONSTELLATIONS];
   logic [7:0]  visible_table_in [CONSTELLATIONS];
   logic [3:0]  used_table_ff [CONSTELLATIONS];
   logic [3:0]  used_table_in [CONSTELLATIONS];
   logic [7:0]  fix_mode_ff, fix_mode_in;
   logic [13:0] pdop_ff, pdop_in;
   logic [7:0]  fix_quality_ff, fix_quality_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        skid_valid_ff, skid_valid_in;
   rsp_type     skid_data_ff, skid_data_in;

   logic        accepted;
   logic        emit;
   rsp_type     result;

   assign req_stall = skid_valid_ff;
   assign accepted  = req_valid && !req_stall;

   always_comb begin
      logic [7:0]  c;
      logic        do_close;
      logic        known;
      logic        is_pdop;
      logic [3:0]  digit;
      logic [16:0] v;

      c        = req_rx_byte;
      do_close = 1'b0;
      emit     = 1'b0;
      known    = 1'b0;
      digit    = 4'(c - CHAR_ZERO);
      v        = 17'(accumulator_ff);
      is_pdop  = (type_code_ff == KIND_GSA) && (field_number_ff == FIELD_PDOP);

      in_sentence_in    = in_sentence_ff;
      field_number_in   = field_number_ff;
      char_in_field_in  = char_in_field_ff;
      talker_code_in    = talker_code_ff;
      type_code_in      = type_code_ff;
      field_nonempty_in = field_nonempty_ff;
      digits_active_in  = digits_active_ff;
      frac_digits_in    = frac_digits_ff;
      accumulator_in    = accumulator_ff;
      used_tally_in     = used_tally_ff;
      visible_table_in  = visible_table_ff;
      used_table_in     = used_table_ff;
      fix_mode_in       = fix_mode_ff;
      pdop_in           = pdop_ff;
      fix_quality_in    = fix_quality_ff;

      if (accepted) begin
         if (c == CHAR_DOLLAR) begin
            in_sentence_in    = 1'b1;
            field_number_in   = FIELD_ADDRESS;
            talker_code_in    = TALKER_NONE;
            type_code_in      = KIND_NONE;
            used_tally_in     = '0;
            char_in_field_in  = '0;
            field_nonempty_in = 1'b0;
            digits_active_in  = 1'b1;
            frac_digits_in    = FRAC_INT;
            accumulator_in    = '0;
         end else if (in_sentence_ff) begin
            if (c == CHAR_COMMA || c == CHAR_STAR || c == CHAR_LF) begin
               do_close = 1'b1;
            end else if (field_number_ff == FIELD_ADDRESS) begin
               unique case (char_in_field_ff)
                  3'd0: begin
                     talker_code_in = (c == CHAR_G) ? TALKER_GP :
                                      (c == CHAR_B) ? TALKER_BD : TALKER_NONE;
                  end
                  3'd1: begin
                     if (talker_code_ff == TALKER_GP) begin
                        talker_code_in = (c == CHAR_P) ? TALKER_GP :
                                         (c == CHAR_L) ? TALKER_GL :
                                         (c == CHAR_A) ? TALKER_GA : TALKER_NONE;
                     end else if (talker_code_ff == TALKER_BD) begin
                        talker_code_in = (c == CHAR_D) ? TALKER_BD : TALKER_NONE;
                     end
                  end
                  3'd2: begin
                     type_code_in = (c == CHAR_G) ? KIND_GGA : KIND_NONE;
                  end
                  3'd3: begin
                     if (type_code_ff == KIND_GGA) begin
                        type_code_in = (c == CHAR_S) ? KIND_GSV :
                                       (c == CHAR_G) ? KIND_GGA : KIND_NONE;
                     end
                  end
                  3'd4: begin
                     if (type_code_ff == KIND_GSV) begin
                        type_code_in = (c == CHAR_V) ? KIND_GSV :
                                       (c == CHAR_A) ? KIND_GSA : KIND_NONE;
                     end else if (type_code_ff == KIND_GGA) begin
                        type_code_in = (c == CHAR_A) ? KIND_GGA : KIND_NONE;
                     end
                  end
                  default: begin
                     type_code_in = KIND_NONE;
                  end
               endcase
               field_nonempty_in = 1'b1;
               if (char_in_field_ff < CHAR_LAST) char_in_field_in = char_in_field_ff + 3'd1;
            end else begin
               if (digits_active_ff) begin
                  if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                     if (is_pdop) begin
                        unique case (frac_digits_ff)
                           FRAC_INT: v = 17'(accumulator_ff) * 17'd10 + 17'(digit) * 17'd100;
                           FRAC_DOT: begin
                              v = 17'(accumulator_ff) + 17'(digit) * 17'd10;
                              frac_digits_in = FRAC_ONE;
                           end
                           FRAC_ONE: begin
                              v = 17'(accumulator_ff) + 17'(digit);
                              frac_digits_in = FRAC_DONE;
                           end
                           default: v = 17'(accumulator_ff);
                        endcase
                        accumulator_in = (v > PDOP_MAX) ? 14'(PDOP_MAX) : v[13:0];
                     end else begin
                        v = 17'(accumulator_ff) * 17'd10 + 17'(digit);
                        accumulator_in = (v > COUNT_MAX) ? 14'(COUNT_MAX) : v[13:0];
                     end
                  end else if (c == CHAR_DOT && is_pdop && frac_digits_ff == FRAC_INT) begin
                     frac_digits_in = FRAC_DOT;
                  end else begin
                     digits_active_in = 1'b0;
                  end
               end
               field_nonempty_in = 1'b1;
               if (char_in_field_ff < CHAR_LAST) char_in_field_in = char_in_field_ff + 3'd1;
            end
         end
      end

      known = (talker_code_ff < TALKER_NONE) && ({1'b0, talker_code_ff} < CONST_LIMIT);

      if (do_close) begin
         if (field_number_ff == FIELD_ADDRESS) begin
            if (char_in_field_ff != ADDRESS_LEN) type_code_in = KIND_NONE;
         end else if (field_nonempty_ff) begin
            if (type_code_ff == KIND_GSV && field_number_ff == FIELD_VISIBLE && known) begin
               for (int i = 0; i < CONSTELLATIONS; i++) begin
                  if (talker_code_ff == 3'(i)) visible_table_in[i] = accumulator_ff[7:0];
               end
            end else if (type_code_ff == KIND_GSA && field_number_ff == FIELD_MODE) begin
               fix_mode_in = accumulator_ff[7:0];
            end else if (type_code_ff == KIND_GSA && field_number_ff == FIELD_PDOP) begin
               pdop_in = accumulator_ff;
            end else if (type_code_ff == KIND_GGA && field_number_ff == FIELD_QUALITY) begin
               fix_quality_in = accumulator_ff[7:0];
            end
            if (type_code_ff == KIND_GSA && field_number_ff >= FIELD_SV_FIRST &&
                field_number_ff <= FIELD_SV_LAST && used_tally_ff < USED_MAX) begin
               used_tally_in = used_tally_ff + 4'd1;
            end
         end
         if (field_number_ff < FIELD_LAST) field_number_in = field_number_ff + 5'd1;
         char_in_field_in  = '0;
         field_nonempty_in = 1'b0;
         digits_active_in  = 1'b1;
         frac_digits_in    = FRAC_INT;
         accumulator_in    = '0;

         if (c == CHAR_LF) begin
            in_sentence_in = 1'b0;
            if (type_code_in != KIND_NONE) begin
               emit = 1'b1;
               if (type_code_in == KIND_GSA && known) begin
                  for (int i = 0; i < CONSTELLATIONS; i++) begin
                     if (talker_code_ff == 3'(i)) used_table_in[i] = used_tally_in;
                  end
               end
            end
         end
      end

      result.sentence_kind   = type_code_in;
      result.constellation   = known ? talker_code_ff : TALKER_NONE;
      result.visible_count   = '0;
      result.used_count      = '0;
      result.fix_mode        = fix_mode_in;
      result.pdop_hundredths = pdop_in;
      result.fix_quality     = fix_quality_in;
      if (known) begin
         for (int i = 0; i < CONSTELLATIONS; i++) begin
            if (talker_code_ff == 3'(i)) begin
               result.visible_count = visible_table_in[i];
               result.used_count    = used_table_in[i];
            end
         end
      end
   end

   // result register with one skid entry behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = emit;
            rsp_data_in  = result;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff    <= 1'b0;
         field_number_ff   <= FIELD_ADDRESS;
         char_in_field_ff  <= '0;
         talker_code_ff    <= TALKER_NONE;
         type_code_ff      <= KIND_NONE;
         field_nonempty_ff <= 1'b0;
         digits_active_ff  <= 1'b0;
         frac_digits_ff    <= FRAC_INT;
         accumulator_ff    <= '0;
         used_tally_ff     <= '0;
         for (int i = 0; i < CONSTELLATIONS; i++) begin
            visible_table_ff[i] <= '0;
            used_table_ff[i]    <= '0;
         end
         fix_mode_ff       <= 8'd1;
         pdop_ff           <= PDOP_RESET;
         fix_quality_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         in_sentence_ff    <= in_sentence_in;
         field_number_ff   <= field_number_in;
         char_in_field_ff  <= char_in_field_in;
         talker_code_ff    <= talker_code_in;
         type_code_ff      <= type_code_in;
         field_nonempty_ff <= field_nonempty_in;
         digits_active_ff  <= digits_active_in;
         frac_digits_ff    <= frac_digits_in;
         accumulator_ff    <= accumulator_in;
         used_tally_ff     <= used_tally_in;
         visible_table_ff  <= visible_table_in;
         used_table_ff     <= used_table_in;
         fix_mode_ff       <= fix_mode_in;
         pdop_ff           <= pdop_in;
         fix_quality_ff    <= fix_quality_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sentence_kind   = rsp_data_ff.sentence_kind;
   assign rsp_constellation   = rsp_data_ff.constellation;
   assign rsp_visible_count   = rsp_data_ff.visible_count;
   assign rsp_used_count      = rsp_data_ff.used_count;
   assign rsp_fix_mode        = rsp_data_ff.fix_mode;
   assign rsp_pdop_hundredths = rsp_data_ff.pdop_hundredths;
   assign rsp_fix_quality     = rsp_data_ff.fix_quality;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a result in front");

   a_kind_recognized: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.sentence_kind != KIND_NONE))
      else $error("result for an unrecognized sentence");

   a_unknown_talker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.constellation == TALKER_NONE) |->
      (rsp_data_ff.visible_count == '0 && rsp_data_ff.used_count == '0))
      else $error("counts reported for an unknown talker");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_tally_ff <= USED_MAX)
      else $error("used tally past its limit");

   a_dollar_opens: assert property (@(posedge clock) disable iff (reset)
      (accepted && req_rx_byte == CHAR_DOLLAR) |=>
      (in_sentence_ff && field_number_ff == FIELD_ADDRESS))
      else $error("start character did not open a sentence");

endmodule
